// ===== src/sph_pkg.sv =====
// ----------------------------------------------------------------------------
// sph_pkg
// shared types, register codes and reset values of the kernel gradient block
// ----------------------------------------------------------------------------
package sph_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_DIMENSION = 2'd0;
    localparam logic [1:0] CFG_INV_H     = 2'd1;
    localparam logic [1:0] CFG_GRAD_FAC  = 2'd2;

    localparam logic [1:0]  DIM_2D        = 2'd2;
    localparam logic [1:0]  RST_DIMENSION = 2'd3;
    localparam logic [31:0] RST_INV_H     = 32'd65536;
    localparam logic [31:0] RST_GRAD_FAC  = 32'd20861;

    // per-word context carried beside the arithmetic
    typedef struct packed {
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic        two_d;
    } t_ctx;

    // context after the region tests
    typedef struct packed {
        t_ctx        ctx;
        logic        support;
        logic        outer;
        logic [17:0] w_inner;
    } t_wctx;

endpackage

// ===== src/sph_sqrt.sv =====
// ----------------------------------------------------------------------------
// sph_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sph_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [63:0]   i_rad,
    input  sph_pkg::t_ctx i_ctx,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output sph_pkg::t_ctx o_ctx
);

    localparam int Steps = sph_pkg::SQRT_STEPS;

    logic          r_valid [Steps];
    logic [33:0]   r_rem   [Steps];
    logic [31:0]   r_root  [Steps];
    logic [63:0]   r_rad   [Steps];
    sph_pkg::t_ctx r_ctx   [Steps];

    genvar k;
    for (k = 0; k < Steps; k++) begin : g_step
        logic          v_in;
        logic [33:0]   rem_in;
        logic [31:0]   root_in;
        logic [63:0]   rad_in;
        sph_pkg::t_ctx ctx_in;
        logic [35:0]   acc;
        logic [35:0]   trial;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign ctx_in  = i_ctx;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign ctx_in  = r_ctx[k-1];
        end

        assign acc   = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (acc >= trial) begin
                r_rem[k]  <= 34'(acc - trial);
                r_root[k] <= {root_in[30:0], 1'b1};
            end else begin
                r_rem[k]  <= acc[33:0];
                r_root[k] <= {root_in[30:0], 1'b0};
            end
            r_rad[k] <= {rad_in[61:0], 2'b00};
            r_ctx[k] <= ctx_in;
        end
    end

    assign o_valid = r_valid[Steps-1];
    assign o_root  = r_root[Steps-1];
    assign o_ctx   = r_ctx[Steps-1];

endmodule

// ===== src/sph_div.sv =====
// ----------------------------------------------------------------------------
// sph_div
// pipelined restoring divider for the outer weight, one quotient bit a stage
// ----------------------------------------------------------------------------
module sph_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [33:0]    i_num,
    input  logic [19:0]    i_den,
    input  sph_pkg::t_wctx i_wctx,
    output logic           o_valid,
    output logic [15:0]    o_quot,
    output sph_pkg::t_wctx o_wctx
);

    localparam int Steps = sph_pkg::DIV_STEPS;

    logic           r_valid [Steps];
    logic [19:0]    r_rem   [Steps];
    logic [15:0]    r_low   [Steps];
    logic [19:0]    r_den   [Steps];
    sph_pkg::t_wctx r_wctx  [Steps];

    genvar k;
    for (k = 0; k < Steps; k++) begin : g_step
        logic           v_in;
        logic [19:0]    rem_in;
        logic [15:0]    low_in;
        logic [19:0]    den_in;
        sph_pkg::t_wctx wctx_in;
        logic [20:0]    acc;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = {2'b00, i_num[33:16]};
            assign low_in  = i_num[15:0];
            assign den_in  = i_den;
            assign wctx_in = i_wctx;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign den_in  = r_den[k-1];
            assign wctx_in = r_wctx[k-1];
        end

        assign acc = {rem_in, low_in[15]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        // quotient bits shift in from the bottom as the dividend leaves the top
        always_ff @(posedge i_clk) begin
            if (acc >= {1'b0, den_in}) begin
                r_rem[k] <= 20'(acc - {1'b0, den_in});
                r_low[k] <= {low_in[14:0], 1'b1};
            end else begin
                r_rem[k] <= acc[19:0];
                r_low[k] <= {low_in[14:0], 1'b0};
            end
            r_den[k]  <= den_in;
            r_wctx[k] <= wctx_in;
        end
    end

    assign o_valid = r_valid[Steps-1];
    assign o_quot  = r_low[Steps-1];
    assign o_wctx  = r_wctx[Steps-1];

endmodule

// ===== src/sph_scale.sv =====
// ----------------------------------------------------------------------------
// sph_scale
// scales each component by the weight, truncates and saturates to q15.16
// ----------------------------------------------------------------------------
module sph_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [49:0]   i_m,
    input  logic          i_support,
    input  sph_pkg::t_ctx i_ctx,
    output logic          o_valid,
    output logic [31:0]   o_grad_x,
    output logic [31:0]   o_grad_y,
    output logic [31:0]   o_grad_z,
    output logic          o_in_support
);

    logic [31:0] mag_in [3];
    logic        neg_in [3];
    logic        en_in  [3];

    logic        r_a_valid;
    logic        r_a_support;
    logic [63:0] r_lo  [3];
    logic [49:0] r_hi  [3];
    logic        r_neg [3];
    logic        r_en  [3];

    logic        r_valid;
    logic        r_support;
    logic [31:0] r_grad [3];

    assign mag_in[0] = i_ctx.mag_x;
    assign mag_in[1] = i_ctx.mag_y;
    assign mag_in[2] = i_ctx.mag_z;
    assign neg_in[0] = i_ctx.neg_x;
    assign neg_in[1] = i_ctx.neg_y;
    assign neg_in[2] = i_ctx.neg_z;
    assign en_in[0]  = i_support;
    assign en_in[1]  = i_support;
    assign en_in[2]  = i_support & ~i_ctx.two_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_support <= i_support;
        r_support   <= r_a_support;
    end

    genvar c;
    for (c = 0; c < 3; c++) begin : g_lane
        logic [50:0] mag;
        logic [31:0] res;

        assign mag = 51'(r_hi[c]) + 51'(r_lo[c][63:32]);

        // gradient sign is opposite to the separation
        always_comb begin
            if (r_neg[c]) begin
                res = (mag > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end else if (mag > 51'h8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = 32'(0 - mag[31:0]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_lo[c]  <= 64'(mag_in[c]) * 64'(i_m[31:0]);
            r_hi[c]  <= 50'(mag_in[c]) * 50'(i_m[49:32]);
            r_neg[c] <= neg_in[c];
            r_en[c]  <= en_in[c];
            r_grad[c] <= r_en[c] ? res : 32'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_in_support = r_support;
    assign o_grad_x     = r_grad[0];
    assign o_grad_y     = r_grad[1];
    assign o_grad_z     = r_grad[2];

endmodule

// ===== src/sph_cubic_spline_gradient_top.sv =====
// ----------------------------------------------------------------------------
// sph_cubic_spline_gradient_top
// cubic spline sph kernel gradient of one separation vector per clock
// ----------------------------------------------------------------------------
// usage
//   a word (i_sep_x, i_sep_y, i_sep_z, signed q15.16) is taken at each rising
//   edge with i_start high and o_busy low; o_busy is always low, so a new
//   word may enter every cycle
//   the gradient comes back on o_grad_x/y/z with o_in_support, marked by
//   o_done for exactly one cycle, in order; the receiver cannot hold
//   results off and none is needed
//   the pipeline is made of the square root (32 stages, one root bit each) and
//   the outer region divider (16 stages, one quotient bit each), plus nine
//   stages of multiply, region test and saturation
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 dimension, 1 inverse smoothing length, 2 gradient factor); the user
//   must write only while no word is in flight; the block does not enforce it
//   reset (synchronous, active low) clears every pipeline valid bit and
//   loads the register reset values; no clearing pass
// ----------------------------------------------------------------------------
module sph_cubic_spline_gradient_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_sep_x,
    input  logic [31:0] i_sep_y,
    input  logic [31:0] i_sep_z,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_grad_x,
    output logic [31:0] o_grad_y,
    output logic [31:0] o_grad_z,
    output logic        o_in_support
);

    // configuration registers
    logic [1:0]  r_dimension;
    logic [31:0] r_inv_h;
    logic [31:0] r_grad_fac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= sph_pkg::RST_DIMENSION;
            r_inv_h     <= sph_pkg::RST_INV_H;
            r_grad_fac  <= sph_pkg::RST_GRAD_FAC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sph_pkg::CFG_DIMENSION: r_dimension <= i_cfg_data[1:0];
                sph_pkg::CFG_INV_H:     r_inv_h     <= i_cfg_data;
                sph_pkg::CFG_GRAD_FAC:  r_grad_fac  <= i_cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // the pipeline never stalls
    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start & ~o_busy;

    // stage 0: magnitudes and signs
    logic          r0_valid;
    sph_pkg::t_ctx r0_ctx;
    logic          two_d_in;

    assign two_d_in = (r_dimension == sph_pkg::DIM_2D);

    always_ff @(posedge i_clk) begin
        r0_ctx.mag_x <= i_sep_x[31] ? 32'(~i_sep_x + 32'd1) : i_sep_x;
        r0_ctx.mag_y <= i_sep_y[31] ? 32'(~i_sep_y + 32'd1) : i_sep_y;
        // z drops out of the norm in 2d mode
        r0_ctx.mag_z <= two_d_in ? 32'd0 :
                        (i_sep_z[31] ? 32'(~i_sep_z + 32'd1) : i_sep_z);
        r0_ctx.neg_x <= i_sep_x[31];
        r0_ctx.neg_y <= i_sep_y[31];
        r0_ctx.neg_z <= i_sep_z[31];
        r0_ctx.two_d <= two_d_in;
    end

    // stage 1: squares
    logic          r1_valid;
    logic [63:0]   r1_sq_x;
    logic [63:0]   r1_sq_y;
    logic [63:0]   r1_sq_z;
    sph_pkg::t_ctx r1_ctx;

    always_ff @(posedge i_clk) begin
        r1_sq_x <= 64'(r0_ctx.mag_x) * 64'(r0_ctx.mag_x);
        r1_sq_y <= 64'(r0_ctx.mag_y) * 64'(r0_ctx.mag_y);
        r1_sq_z <= 64'(r0_ctx.mag_z) * 64'(r0_ctx.mag_z);
        r1_ctx  <= r0_ctx;
    end

    // stage 2: squared norm, at most 3 * 2^62 so it fits 64 bits
    logic          r2_valid;
    logic [63:0]   r2_sum;
    sph_pkg::t_ctx r2_ctx;

    always_ff @(posedge i_clk) begin
        r2_sum <= r1_sq_x + r1_sq_y + r1_sq_z;
        r2_ctx <= r1_ctx;
    end

    // norm |r| in q16
    logic          sq_valid;
    logic [31:0]   sq_root;
    sph_pkg::t_ctx sq_ctx;

    sph_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_rad   (r2_sum),
        .i_ctx   (r2_ctx),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_ctx   (sq_ctx)
    );

    // stage 3: s in q32
    logic          r3_valid;
    logic [63:0]   r3_p;
    sph_pkg::t_ctx r3_ctx;

    always_ff @(posedge i_clk) begin
        r3_p   <= 64'(sq_root) * 64'(r_inv_h);
        r3_ctx <= sq_ctx;
    end

    // stage 4: region tests, inner weight and 2 - s
    logic           r4_valid;
    sph_pkg::t_wctx r4_wctx;
    logic [17:0]    r4_s16;
    logic [16:0]    r4_t;
    logic [17:0]    s16;
    logic [21:0]    nine_s;

    assign s16    = r3_p[33:16];
    assign nine_s = 22'(s16) * 22'd9 + 22'd3;

    always_ff @(posedge i_clk) begin
        r4_wctx.ctx     <= r3_ctx;
        r4_wctx.support <= (r3_p <= 64'h2_0000_0000);
        r4_wctx.outer   <= (r3_p >  64'h1_0000_0000);
        // 3 - ceil(9 s / 4) in q16; only taken for s at most 1
        r4_wctx.w_inner <= 18'(20'd196608 - 20'(nine_s[21:2]));
        r4_s16          <= s16;
        // only taken in the outer band, where s16 lies in 65536 .. 131072
        r4_t            <= 17'(18'd131072 - s16);
    end

    // stage 5: outer numerator 3 t^2 and denominator 4 s
    logic           r5_valid;
    logic [33:0]    r5_num;
    logic [19:0]    r5_den;
    sph_pkg::t_wctx r5_wctx;
    logic [33:0]    t_sq;

    assign t_sq = 34'(r4_t) * 34'(r4_t);

    always_ff @(posedge i_clk) begin
        r5_num  <= 34'({t_sq, 1'b0} + {1'b0, t_sq});
        r5_den  <= {r4_s16, 2'b00};
        r5_wctx <= r4_wctx;
    end

    logic           dv_valid;
    logic [15:0]    dv_quot;
    sph_pkg::t_wctx dv_wctx;

    sph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_valid),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_wctx  (r5_wctx),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_wctx  (dv_wctx)
    );

    // stage 6: weight times gradient factor, exact in q32
    logic          r6_valid;
    logic [49:0]   r6_m;
    logic          r6_support;
    sph_pkg::t_ctx r6_ctx;
    logic [17:0]   w_mag;

    assign w_mag = dv_wctx.outer ? {2'b00, dv_quot} : dv_wctx.w_inner;

    always_ff @(posedge i_clk) begin
        r6_m       <= 50'(r_grad_fac) * 50'(w_mag);
        r6_support <= dv_wctx.support;
        r6_ctx     <= dv_wctx.ctx;
    end

    // valid bits beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r0_valid <= accept;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= sq_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= dv_valid;
        end
    end

    // last two stages: component scaling and saturation
    sph_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r6_valid),
        .i_m          (r6_m),
        .i_support    (r6_support),
        .i_ctx        (r6_ctx),
        .o_valid      (o_done),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_grad_z     (o_grad_z),
        .o_in_support (o_in_support)
    );

endmodule
